### rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int MASK_LEN = 64;
    localparam int NPOS = MASK_LEN + 1;
    localparam int CNT_W = $clog2(MASK_LEN + 1);
    localparam int SCAN_LEVELS = $clog2(NPOS);

    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] QUESTION_CODE = 8'h3F;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        ACT_MASK  = 2'd0,
        ACT_NAME  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic mask_clear;
        logic mask_wr;
        logic name_step;
    } cell_ctl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            return c - CASE_BIT;
        end
        return c;
    endfunction

endpackage

### rtl/wgm_in_if.sv
interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, action, char_code, last, input ready);
    modport sink (input valid, action, char_code, last, output ready);
endinterface

### rtl/wgm_out_if.sv
interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic mask_too_long;

    modport source (output valid, matched, mask_too_long, input ready);
    modport sink (input valid, matched, mask_too_long, output ready);
endinterface

### rtl/wgm_cell.sv
module wgm_cell
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic       wr_sel,
    input  logic [7:0] char_code,
    input  logic       cur,
    input  logic       adv_in,
    output logic       adv_out,
    output logic       seed,
    output logic       prop
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;
    logic       wr;
    logic       hit;
    logic       is_star;

    assign wr = ctl.mask_wr & wr_sel;
    assign byte_next = wr ? char_code : byte_reg;
    assign valid_next = ctl.mask_clear ? wr : (valid_reg | wr);

    // star in the mask as it stands after this cycle lets reach run on
    assign prop = valid_next & (byte_next == STAR_CODE);

    assign hit = cur & valid_reg;
    assign is_star = byte_reg == STAR_CODE;
    assign adv_out = hit & ~is_star
                   & ((byte_reg == QUESTION_CODE) | (fold_case(byte_reg) == fold_case(char_code)));
    assign seed = ctl.name_step & ((hit & is_star) | adv_in);

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

### rtl/wgm_star_scan.sv
module wgm_star_scan
    import wgm_pkg::*;
(
    input  logic [NPOS-1:0]     seed,
    input  logic [MASK_LEN-1:0] prop,
    output logic [NPOS-1:0]     closed
);

    // prefix scan: position j reached if a seed at i <= j and stars fill i..j-1
    logic [NPOS-1:0] g [SCAN_LEVELS+1];
    logic [NPOS-1:0] p [SCAN_LEVELS+1];

    always_comb
    begin
        g[0] = seed;
        p[0] = {prop, 1'b0};
        for (int l = 0; l < SCAN_LEVELS; l++)
        begin
            for (int j = 0; j < NPOS; j++)
            begin
                if (j >= (1 << l))
                begin
                    g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
                    p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
                end
                else
                begin
                    g[l+1][j] = g[l][j];
                    p[l+1][j] = p[l][j];
                end
            end
        end
    end

    assign closed = g[SCAN_LEVELS] | (p[SCAN_LEVELS] & '0);

endmodule

### rtl/wildcard_glob_matcher.sv
// result: registered in the output register, or in the skid stage while that is stalled
// throughput: one item per cycle, mask bytes and name bytes alike
// the active-position set is updated for every mask position at once by the cell row
// and a log-depth star scan; item stalls only when output register and skid are both full
// reset: empty mask loaded, no name in progress, output empty; no clearing pass
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wgm_in_if.sink     item,
    wgm_out_if.source  result
);

    logic             accept;
    logic             is_mask;
    logic             is_name;
    logic             is_query;
    logic             new_mask;
    logic             room;
    logic [CNT_W-1:0] count_base;
    logic             ovf_base;
    cell_ctl_t        ctl;

    logic [CNT_W-1:0] mask_count_reg;
    logic [CNT_W-1:0] mask_count_next;
    logic             mask_complete_reg;
    logic             mask_complete_next;
    logic             mask_overflow_reg;
    logic             mask_overflow_next;
    logic             name_started_reg;
    logic             name_started_next;
    logic [NPOS-1:0]  active_reg;
    logic [NPOS-1:0]  active_next;
    logic [NPOS-1:0]  start_reg;
    logic [NPOS-1:0]  start_next;

    logic [MASK_LEN-1:0] wr_sel;
    logic [NPOS-1:0]     cur;
    logic [MASK_LEN:0]   adv;
    logic [MASK_LEN-1:0] cell_seed;
    logic [MASK_LEN-1:0] prop;
    logic [NPOS-1:0]     seed;
    logic [NPOS-1:0]     closed;

    logic produce;
    logic res_matched;
    logic out_valid_reg;
    logic out_matched_reg;
    logic out_long_reg;
    logic skid_valid_reg;
    logic skid_matched_reg;
    logic skid_long_reg;
    logic out_load;

    assign item.ready = ~skid_valid_reg;
    assign accept = item.valid & item.ready;
    assign is_mask = accept & (item.action == ACT_MASK);
    assign is_name = accept & (item.action == ACT_NAME);
    assign is_query = accept & (item.action == ACT_QUERY);

    assign new_mask = is_mask & mask_complete_reg;
    assign count_base = new_mask ? '0 : mask_count_reg;
    assign ovf_base = new_mask ? 1'b0 : mask_overflow_reg;
    assign room = count_base < CNT_W'(MASK_LEN);

    assign ctl.mask_clear = new_mask;
    assign ctl.mask_wr = is_mask & room;
    assign ctl.name_step = is_name;

    assign cur = name_started_reg ? active_reg : start_reg;
    assign adv[0] = 1'b0;

    for (genvar i = 0; i < MASK_LEN; i++)
    begin : g_cell
        assign wr_sel[i] = count_base == CNT_W'(i);

        wgm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_sel    (wr_sel[i]),
            .char_code (item.char_code),
            .cur       (cur[i]),
            .adv_in    (adv[i]),
            .adv_out   (adv[i+1]),
            .seed      (cell_seed[i]),
            .prop      (prop[i])
        );
    end

    // a mask byte restarts the name: only position zero seeds the scan
    assign seed = {adv[MASK_LEN] & is_name, cell_seed} | {{MASK_LEN{1'b0}}, is_mask};

    wgm_star_scan u_scan (
        .seed   (seed),
        .prop   (prop),
        .closed (closed)
    );

    always_comb
    begin
        mask_count_next = mask_count_reg;
        mask_overflow_next = mask_overflow_reg;
        mask_complete_next = mask_complete_reg;
        name_started_next = name_started_reg;
        active_next = active_reg;
        start_next = start_reg;
        if (is_mask)
        begin
            mask_count_next = room ? count_base + CNT_W'(1) : count_base;
            mask_overflow_next = ovf_base | ~room;
            mask_complete_next = item.last;
            name_started_next = 1'b0;
            active_next = closed;
            start_next = closed;
        end
        else if (is_name)
        begin
            name_started_next = ~item.last;
            active_next = closed;
        end
        else if (is_query)
        begin
            name_started_next = 1'b0;
        end
    end

    assign produce = (is_name & item.last) | is_query;
    assign res_matched = ~mask_overflow_reg
                       & (is_query ? start_reg[mask_count_reg] : closed[mask_count_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_count_reg <= '0;
            mask_complete_reg <= 1'b1;
            mask_overflow_reg <= 1'b0;
            name_started_reg <= 1'b0;
            active_reg <= NPOS'(1);
            start_reg <= NPOS'(1);
        end
        else
        begin
            mask_count_reg <= mask_count_next;
            mask_complete_reg <= mask_complete_next;
            mask_overflow_reg <= mask_overflow_next;
            name_started_reg <= name_started_next;
            active_reg <= active_next;
            start_reg <= start_next;
        end
    end

    // output register with a skid stage behind it
    assign out_load = ~out_valid_reg | result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= skid_valid_reg | produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_matched_reg <= skid_matched_reg;
                out_long_reg <= skid_long_reg;
            end
            else
            begin
                out_matched_reg <= res_matched;
                out_long_reg <= mask_overflow_reg;
            end
        end
        else if (produce)
        begin
            skid_matched_reg <= res_matched;
            skid_long_reg <= mask_overflow_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.matched = out_matched_reg;
    assign result.mask_too_long = out_long_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        mask_count_reg <= CNT_W'(MASK_LEN))
        else $error("mask count beyond capacity");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        mask_overflow_reg |-> (mask_count_reg == CNT_W'(MASK_LEN)))
        else $error("overflow flagged on a mask that is not full");

    a_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg[0])
        else $error("start set lost position zero");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> result.valid)
        else $error("accepted query gave no result");

endmodule
